FILE: rtl/bfpa_pkg.sv
// Shared constants and types of the best-fit page run allocator.
package bfpa_pkg;

   localparam int TotalPages = 128;
   localparam int PageSize   = 4096;
   localparam int MaxRuns    = 64;
   localparam logic [31:0] BaseReset = 32'h0070_0000;

   localparam int PageShift = $clog2(PageSize);
   localparam int RunW      = 8;
   localparam int IdxW      = $clog2(MaxRuns);
   localparam int CntW      = $clog2(MaxRuns + 1);
   localparam int PagesW    = 21 - PageShift;
   localparam int ArW       = ((PagesW > RunW) ? PagesW : RunW) + 1;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_ALLOCATED = 2'd0,
      STAT_FREED     = 2'd1,
      STAT_NO_FIT    = 2'd2,
      STAT_LIST_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_DN,
      S_SHIFT_UP,
      S_WRITE_NEW,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [RunW-1:0] start;
      logic [RunW-1:0] length;
   } run_type;

endpackage

FILE: rtl/bfpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfpa_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/best_fit_page_run_allocator.sv
// Top level of the best-fit page run allocator: sequencer, run list and result register.
//
// The block manages TotalPages pages of PageSize bytes starting at region_base.
// Free space is an address-sorted list of runs held in a one-port-each RAM.
// Requests arrive on the req_ channel (valid/ready); an allocate returns the byte
// address of the chosen run's front, a free merges pages back into the list.
// Each request produces exactly one transfer on the rsp_ channel.
// One request is worked at a time: req_ready is high only while the sequencer idles.
// A request scans the list once through the RAM read port, decides in S_DECIDE,
// and may then move entries up or down one per cycle (when a new run is opened,
// S_WRITE_NEW then writes it), and finally loads the result register in S_RESP.
// The result sits in an output register; if the receiver stalls, the block holds
// the finished result and waits before loading the next one, so no result is lost.
// Reset is synchronous and active high; after reset the sequencer first writes
// the single run covering the whole region, then raises req_ready.
// The user must write region_base through csr_write_enable/csr_write_data only while
// idle; the block itself does not enforce this.
module best_fit_page_run_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [19:0] req_byte_size,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_block_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import bfpa_pkg::*;

   state_type         state_ff, state_in;
   logic [31:0]       base_ff, base_in;
   logic [CntW-1:0]   count_ff, count_in;
   op_type            op_ff, op_in;
   logic [PagesW-1:0] pages_ff, pages_in;
   logic [RunW-1:0]   page_ff, page_in;
   logic [RunW:0]     end_ff, end_in;
   logic              bad_ff, bad_in;
   logic [CntW-1:0]   scan_ff, scan_in;
   logic [CntW-1:0]   ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [IdxW-1:0]   pend_idx_ff, pend_idx_in;
   logic              found_ff, found_in;
   logic              exact_ff, exact_in;
   logic [IdxW-1:0]   best_idx_ff, best_idx_in;
   run_type           best_ff, best_in;
   logic              overlap_ff, overlap_in;
   logic              lv_ff, lv_in;
   logic [IdxW-1:0]   left_idx_ff, left_idx_in;
   run_type           left_ff, left_in;
   logic              rf_ff, rf_in;
   logic [IdxW-1:0]   right_idx_ff, right_idx_in;
   run_type           right_ff, right_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              ram_we;
   logic [IdxW-1:0]   ram_waddr;
   run_type           ram_wdata;
   logic [IdxW-1:0]   ram_raddr;
   logic [2*RunW-1:0] ram_rdata;
   run_type           rd;

   logic [31:0]       diff;
   logic [31:0]       pg;
   logic [ArW-1:0]    rd_len_x, pages_x, rd_end_x;
   logic              left_hit, right_hit;
   logic [CntW-1:0]   ins_idx;

   bfpa_ram #(
      .Width(2 * RunW),
      .Depth(MaxRuns)
   ) u_runs (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd = run_type'(ram_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         base_ff      <= BaseReset;
         count_ff     <= CntW'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pages_ff      <= pages_in;
      page_ff       <= page_in;
      end_ff        <= end_in;
      bad_ff        <= bad_in;
      scan_ff       <= scan_in;
      ptr_ff        <= ptr_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      exact_ff      <= exact_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      overlap_ff    <= overlap_in;
      lv_ff         <= lv_in;
      left_idx_ff   <= left_idx_in;
      left_ff       <= left_in;
      rf_ff         <= rf_in;
      right_idx_ff  <= right_idx_in;
      right_ff      <= right_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      base_in       = csr_write_enable ? csr_write_data : base_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      pages_in      = pages_ff;
      page_in       = page_ff;
      end_in        = end_ff;
      bad_in        = bad_ff;
      scan_in       = scan_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      exact_in      = exact_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      overlap_in    = overlap_ff;
      lv_in         = lv_ff;
      left_idx_in   = left_idx_ff;
      left_in       = left_ff;
      rf_in         = rf_ff;
      right_idx_in  = right_idx_ff;
      right_in      = right_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      req_ready     = 1'b0;

      diff     = req_address - base_ff;
      pg       = diff >> PageShift;
      rd_len_x = ArW'(rd.length);
      rd_end_x = ArW'(rd.start) + ArW'(rd.length);
      pages_x  = ArW'(pages_ff);
      left_hit = lv_ff && ((ArW'(left_ff.start) + ArW'(left_ff.length)) == ArW'(page_ff));
      right_hit = rf_ff && (ArW'(right_ff.start) == ArW'(end_ff));
      ins_idx  = rf_ff ? CntW'(right_idx_ff) : count_ff;

      unique case (state_ff)
         S_INIT: begin
            // Seed the list with one run covering the whole region.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{start: '0, length: RunW'(TotalPages)};
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = op_type'(req_operation);
               pages_in   = PagesW'(req_byte_size >> PageShift) + PagesW'(1);
               page_in    = pg[RunW-1:0];
               end_in     = (RunW+1)'(pg[RunW-1:0]) +
                            (RunW+1)'(PagesW'(req_byte_size >> PageShift) + PagesW'(1));
               bad_in     = (pg >= 32'(TotalPages)) ||
                            (32'(PagesW'(req_byte_size >> PageShift) + PagesW'(1)) >
                             (32'(TotalPages) - pg));
               scan_in    = '0;
               pend_in    = 1'b0;
               found_in   = 1'b0;
               exact_in   = 1'b0;
               overlap_in = 1'b0;
               lv_in      = 1'b0;
               rf_in      = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pend_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if (!exact_ff) begin
                     if (rd_len_x == pages_x) begin
                        exact_in    = 1'b1;
                        found_in    = 1'b1;
                        best_idx_in = pend_idx_ff;
                        best_in     = rd;
                     end else if (rd_len_x > pages_x &&
                                  (!found_ff || rd.length < best_ff.length)) begin
                        found_in    = 1'b1;
                        best_idx_in = pend_idx_ff;
                        best_in     = rd;
                     end
                  end
               end else begin
                  if (ArW'(rd.start) < ArW'(end_ff) && ArW'(page_ff) < rd_end_x) begin
                     overlap_in = 1'b1;
                  end
                  if (rd.start <= page_ff) begin
                     lv_in       = 1'b1;
                     left_idx_in = pend_idx_ff;
                     left_in     = rd;
                  end else if (!rf_ff) begin
                     rf_in        = 1'b1;
                     right_idx_in = pend_idx_ff;
                     right_in     = rd;
                  end
               end
            end
            if (scan_ff < count_ff) begin
               ram_raddr   = scan_ff[IdxW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IdxW-1:0];
               scan_in     = scan_ff + CntW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            pend_in = 1'b0;
            if (op_ff == OP_ALLOC) begin
               if (!found_ff) begin
                  res_addr_in   = '0;
                  res_status_in = STAT_NO_FIT;
                  state_in      = S_RESP;
               end else begin
                  res_addr_in   = base_ff + (32'(best_ff.start) << PageShift);
                  res_status_in = STAT_ALLOCATED;
                  if (exact_ff) begin
                     ptr_in   = CntW'(best_idx_ff) + CntW'(1);
                     state_in = S_SHIFT_DN;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = best_idx_ff;
                     ram_wdata = '{start: best_ff.start + pages_ff[RunW-1:0],
                                   length: best_ff.length - pages_ff[RunW-1:0]};
                     state_in  = S_RESP;
                  end
               end
            end else begin
               res_addr_in   = '0;
               res_status_in = STAT_FREED;
               state_in      = S_RESP;
               if (!bad_ff && !overlap_ff) begin
                  if (left_hit && right_hit) begin
                     ram_we    = 1'b1;
                     ram_waddr = left_idx_ff;
                     ram_wdata = '{start: left_ff.start,
                                   length: left_ff.length + pages_ff[RunW-1:0] +
                                           right_ff.length};
                     ptr_in    = CntW'(right_idx_ff) + CntW'(1);
                     state_in  = S_SHIFT_DN;
                  end else if (right_hit) begin
                     ram_we    = 1'b1;
                     ram_waddr = right_idx_ff;
                     ram_wdata = '{start: page_ff,
                                   length: right_ff.length + pages_ff[RunW-1:0]};
                  end else if (left_hit) begin
                     ram_we    = 1'b1;
                     ram_waddr = left_idx_ff;
                     ram_wdata = '{start: left_ff.start,
                                   length: left_ff.length + pages_ff[RunW-1:0]};
                  end else if (count_ff == CntW'(MaxRuns)) begin
                     res_status_in = STAT_LIST_FULL;
                  end else begin
                     ptr_in   = count_ff;
                     state_in = S_SHIFT_UP;
                  end
               end
            end
         end
         S_SHIFT_DN: begin
            // Close the gap: each entry above the dropped one moves down a slot.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_idx_ff - IdxW'(1);
               ram_wdata = rd;
            end
            if (ptr_ff < count_ff) begin
               ram_raddr   = ptr_ff[IdxW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IdxW-1:0];
               ptr_in      = ptr_ff + CntW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CntW'(1);
                  state_in = S_RESP;
               end
            end
         end
         S_SHIFT_UP: begin
            // Open a slot at the insertion point, working from the top down.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_idx_ff + IdxW'(1);
               ram_wdata = rd;
            end
            if (ptr_ff > ins_idx) begin
               ram_raddr   = IdxW'(ptr_ff - CntW'(1));
               pend_in     = 1'b1;
               pend_idx_in = IdxW'(ptr_ff - CntW'(1));
               ptr_in      = ptr_ff - CntW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_WRITE_NEW;
               end
            end
         end
         S_WRITE_NEW: begin
            ram_we    = 1'b1;
            ram_waddr = ins_idx[IdxW-1:0];
            ram_wdata = '{start: page_ff, length: pages_ff[RunW-1:0]};
            count_in  = count_ff + CntW'(1);
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxRuns))
      else $error("run count exceeds list capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_ALLOCATED |-> rsp_block_address == 32'd0)
      else $error("nonzero address on a non-allocate result");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> CntW'(ram_waddr) <= count_ff)
      else $error("run write beyond end of list");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("finished result was not presented");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the best-fit page run allocator.
`timescale 1ns / 100ps

module tb_top;
   import bfpa_pkg::*;

   typedef struct {
      op_type      op;
      logic [19:0] size;
      logic [31:0] addr;
   } page_req_type;

   typedef struct {
      logic [31:0] block_addr;
      status_type  status;
   } page_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [19:0] req_byte_size = '0;
   logic [31:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_block_address;
   logic [1:0]  rsp_status;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   best_fit_page_run_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_byte_size(req_byte_size),
      .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_block_address(rsp_block_address), .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // Predictor state: our own copy of the free-run list and the base register.
   logic [31:0] base_addr;
   int          free_start[MaxRuns];
   int          free_len[MaxRuns];
   int          free_count;

   page_req_type pending_reqs[$];
   page_rsp_type expected_rsps[$];
   int           fail_count = 0;

   function automatic void reset_free_list();
      free_count    = 1;
      free_start[0] = 0;
      free_len[0]   = TotalPages;
   endfunction

   function automatic void remove_run(int idx);
      for (int k = idx; k + 1 < free_count; k++) begin
         free_start[k] = free_start[k+1];
         free_len[k]   = free_len[k+1];
      end
      if (free_count > 0) free_count--;
   endfunction

   // Computes the result of one request and updates the predicted free list.
   function automatic page_rsp_type apply_page_request(page_req_type r);
      page_rsp_type res;
      int           pages, pick, page, last, i;
      bit           found, left, right;
      logic [31:0]  offs;
      pages = int'(r.size) / PageSize + 1;
      res.block_addr = '0;
      if (r.op == OP_ALLOC) begin
         found = 0;
         pick  = 0;
         for (int k = 0; k < free_count; k++) begin
            if (free_len[k] == pages) begin
               pick = k;
               found = 1;
               break;
            end
            if (free_len[k] > pages && (!found || free_len[k] < free_len[pick])) begin
               pick = k;
               found = 1;
            end
         end
         if (!found) begin
            res.status = STAT_NO_FIT;
            return res;
         end
         res.block_addr = base_addr + 32'(free_start[pick] * PageSize);
         res.status     = STAT_ALLOCATED;
         if (free_len[pick] == pages) remove_run(pick);
         else begin
            free_start[pick] += pages;
            free_len[pick]   -= pages;
         end
         return res;
      end
      res.status = STAT_FREED;
      offs = r.addr - base_addr;
      if (offs >= 32'(TotalPages * PageSize)) return res;
      page = int'(offs) / PageSize;
      if (pages > TotalPages - page) return res;
      last = page + pages;
      // A free that touches any free page is dropped silently.
      for (int k = 0; k < free_count; k++)
         if (free_start[k] < last && page < free_start[k] + free_len[k]) return res;
      i = 0;
      while (i < free_count && free_start[i] <= page) i++;
      left  = (i > 0) && (free_start[i-1] + free_len[i-1] == page);
      right = (i < free_count) && (free_start[i] == last);
      if (left && right) begin
         free_len[i-1] += pages + free_len[i];
         remove_run(i);
      end else if (right) begin
         free_start[i] = page;
         free_len[i]  += pages;
      end else if (left) begin
         free_len[i-1] += pages;
      end else begin
         if (free_count >= MaxRuns) begin
            res.status = STAT_LIST_FULL;
            return res;
         end
         for (int k = free_count; k > i; k--) begin
            free_start[k] = free_start[k-1];
            free_len[k]   = free_len[k-1];
         end
         free_start[i] = page;
         free_len[i]   = pages;
         free_count++;
      end
      return res;
   endfunction

   // The accepting edge is recorded at the rising edge, since req_ready drops
   // right after a transfer.
   bit req_taken = 1'b0;
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
   end

   // Driver: one transfer at a time from the pending queue, with random gaps.
   int           send_gap = 0;
   page_req_type cur_req;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_rsps.push_back(apply_page_request(cur_req));
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
         end
         if (!req_valid || req_taken) begin
            if (send_gap > 0 || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               cur_req = pending_reqs.pop_front();
               req_valid     <= 1'b1;
               req_operation <= cur_req.op;
               req_byte_size <= cur_req.size;
               req_address   <= cur_req.addr;
            end
         end
      end
   end

   // Monitor: checks every accepted result against the oldest expectation.
   int           recv_gap = 0;
   page_rsp_type exp_rsp;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: block_address %h status %0d",
                   rsp_block_address, rsp_status);
            fail_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_block_address !== exp_rsp.block_addr) begin
               $error("block_address: expected %h actual %h",
                      exp_rsp.block_addr, rsp_block_address);
               fail_count++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $error("status: expected %0d actual %0d", exp_rsp.status, rsp_status);
               fail_count++;
            end
         end
         recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end
   end

   // Receiver stalls are drawn per result and counted down on falling edges.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap--;
      end else rsp_ready <= 1'b1;
   end

   function automatic page_req_type make_req(op_type op, logic [19:0] size,
                                             logic [31:0] addr);
      page_req_type r;
      r.op = op;
      r.size = size;
      r.addr = addr;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      // Allow the sequencer to settle before touching the register.
      repeat (2 * MaxRuns + 10) @(negedge clock);
   endtask

   task automatic write_base(logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      base_addr = value;
   endtask

   // Random phase: allocations and frees at random pages, plus noise and single-page frees.
   task automatic random_phase(int count, int max_pages);
      logic [31:0] a;
      int          n, j;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = $urandom_range(1, max_pages);
               pending_reqs.push_back(make_req(OP_ALLOC,
                  20'((n - 1) * PageSize + $urandom_range(0, PageSize - 1)), $urandom()));
            end
            4, 5, 6: begin
               // Frees are not generated against the predicted free list; overlap cases are
               // handled by the predictor either way.
               n = $urandom_range(1, 8);
               a = base_addr + 32'($urandom_range(0, TotalPages - 1) * PageSize)
                   + ($urandom_range(0, 1) ? 32'($urandom_range(0, PageSize - 1)) : 0);
               pending_reqs.push_back(make_req(OP_FREE,
                  20'((n - 1) * PageSize + $urandom_range(0, PageSize - 1)), a));
            end
            7: pending_reqs.push_back(make_req(OP_ALLOC, 20'($urandom()), $urandom()));
            8: pending_reqs.push_back(make_req(OP_FREE, 20'($urandom()), $urandom()));
            default: begin
               // Single-page frees on odd pages break the list into many runs.
               j = $urandom_range(0, TotalPages / 2 - 1) * 2 + 1;
               pending_reqs.push_back(make_req(OP_FREE, 20'($urandom_range(0, PageSize - 1)),
                  base_addr + 32'(j * PageSize)));
            end
         endcase
      end
   endtask

   // Fills the region with one-page blocks, then frees every other page so the
   // list reaches its capacity, then tries a two-page allocate and three more frees.
   task automatic fragment_phase();
      for (int k = 0; k < TotalPages; k++)
         pending_reqs.push_back(make_req(OP_ALLOC, 20'($urandom_range(0, PageSize - 1)), '0));
      for (int k = 0; k < TotalPages; k += 2)
         pending_reqs.push_back(make_req(OP_FREE, 20'($urandom_range(0, PageSize - 1)),
            base_addr + 32'(k * PageSize)));
      pending_reqs.push_back(make_req(OP_ALLOC, 20'(PageSize), '0));
      pending_reqs.push_back(make_req(OP_FREE, '0, base_addr + 32'(1 * PageSize)));
      pending_reqs.push_back(make_req(OP_FREE, '0, base_addr + 32'(3 * PageSize)));
      pending_reqs.push_back(make_req(OP_FREE, 20'(PageSize * 2), base_addr + 32'(5 * PageSize)));
   endtask

   initial begin
      base_addr = BaseReset;
      reset_free_list();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes of the fields and each special case.
      pending_reqs.push_back(make_req(OP_ALLOC, 20'hFFFFF, 32'hFFFF_FFFF)); // oversized
      pending_reqs.push_back(make_req(OP_ALLOC, '0, '0));
      pending_reqs.push_back(make_req(OP_ALLOC, 20'(PageSize - 1), '0));
      pending_reqs.push_back(make_req(OP_ALLOC, 20'(PageSize), '0));
      pending_reqs.push_back(make_req(OP_ALLOC, 20'(3 * PageSize), '0));
      pending_reqs.push_back(make_req(OP_FREE, '0, BaseReset + 32'(PageSize) + 32'd17));
      pending_reqs.push_back(make_req(OP_FREE, '0, BaseReset));              // merge right
      pending_reqs.push_back(make_req(OP_FREE, '0, BaseReset));              // overlap
      pending_reqs.push_back(make_req(OP_FREE, 20'(PageSize), BaseReset + 32'(3 * PageSize)));
      pending_reqs.push_back(make_req(OP_FREE, '0, 32'h0));                  // outside
      pending_reqs.push_back(make_req(OP_FREE, 20'hFFFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_FREE, '0,
         BaseReset + 32'((TotalPages - 1) * PageSize)));                     // last page, overlap
      pending_reqs.push_back(make_req(OP_ALLOC, 20'((TotalPages - 1) * PageSize), '0)); // no fit
      pending_reqs.push_back(make_req(OP_ALLOC, '0, '0));                    // smallest fitting run
      pending_reqs.push_back(make_req(OP_FREE, 20'((TotalPages - 1) * PageSize), BaseReset));
      pending_reqs.push_back(make_req(OP_FREE, '0, BaseReset + 32'((TotalPages - 1) * PageSize)));
      pending_reqs.push_back(make_req(OP_FREE, '0, BaseReset + 32'(TotalPages * PageSize)));
      wait_drained();  // the sender pauses until all results are back

      random_phase(250, 16);
      wait_drained();
      fragment_phase();
      wait_drained();

      // Register extremes: base at the top of the address space wraps around.
      write_base(32'hFFFF_F000);
      random_phase(150, 40);
      wait_drained();
      write_base(32'h0000_0000);
      random_phase(150, 8);
      pending_reqs.push_back(make_req(OP_FREE, '0, 32'hFFFF_FFFF));
      wait_drained();
      write_base($urandom());
      random_phase(150, TotalPages);
      wait_drained();

      if (fail_count == 0) $display("best_fit_page_run_allocator test passed");
      else $display("best_fit_page_run_allocator test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("best_fit_page_run_allocator test failed");
      $finish;
   end

endmodule
